### hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge outside reset that prop implies cons.
`define ASSERT_IMPL(label, clk, rst, prop, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop) |-> (cons)) \
    else $error(msg);

// Check that prop at one edge implies cons at the next edge.
`define ASSERT_NEXT(label, clk, rst, prop, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop) |=> (cons)) \
    else $error(msg);

`endif

### hdl/irbp_pkg.sv
// Shared constants, header duration table and control types of the Pronto encoder.
package irbp_pkg;

  localparam int CODE_W    = 12;
  localparam int DUR_W     = 9;
  localparam int CNT_W     = 6;
  localparam int STEP_W    = 5;

  localparam logic [CNT_W-1:0]  CNT_BASE   = 6'd30;
  localparam logic [DUR_W-1:0]  HALF_BIT   = 9'h020;
  localparam logic [DUR_W-1:0]  HDR_TAIL   = 9'h0fa;
  localparam logic [DUR_W-1:0]  CLOSE_DUR  = 9'h001;
  localparam logic [15:0]       CARRIER_RST = 16'h006d;
  localparam logic [STEP_W-1:0] HDR_LAST   = 5'd16;
  localparam logic [STEP_W-1:0] CODE_LAST  = 5'd11;
  localparam logic [STEP_W-1:0] PRE_LAST   = 5'd3;
  localparam logic [STEP_W-1:0] HALF_LAST  = 5'd23;

  localparam logic [STEP_W-1:0] PRE_ZERO0   = 5'd0;
  localparam logic [STEP_W-1:0] PRE_CARRIER = 5'd1;
  localparam logic [STEP_W-1:0] PRE_ZERO1   = 5'd2;
  localparam logic [STEP_W-1:0] PRE_COUNT   = 5'd3;

  typedef struct packed {
    logic clear;
    logic step;
    logic first;
    logic last;
  } cnt_ctrl_t;

  // Merged header durations, all but the final off edge.
  function automatic logic [DUR_W-1:0] hdr_dur(input logic [STEP_W-1:0] idx);
    logic [DUR_W-1:0] d;
    case (idx)
      5'd0:    d = 9'h0ba;
      5'd1:    d = 9'h0ba;
      5'd3:    d = 9'h040;
      5'd5:    d = 9'h040;
      5'd7:    d = 9'h040;
      5'd11:   d = 9'h040;
      5'd13:   d = 9'h040;
      5'd15:   d = 9'h040;
      default: d = 9'h020;
    endcase
    return d;
  endfunction

endpackage

### hdl/irbp_pair_cnt.sv
// Bit-serial duration counter that yields the burst-pair count of a code.
module irbp_pair_cnt
  import irbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cnt_ctrl_t       ctrl,
  input  logic            code_bit,
  output logic [CNT_W-2:0] pair_count
);

  logic [CNT_W-1:0] cnt;
  logic             prev;
  logic [CNT_W-1:0] inc;

  always_comb begin
    inc = CNT_W'(ctrl.first ? !code_bit : (code_bit == prev));
    if (ctrl.last) begin
      inc = inc + CNT_W'(code_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= CNT_BASE;
      prev <= 1'b0;
    end else if (ctrl.clear) begin
      cnt  <= CNT_BASE;
      prev <= 1'b0;
    end else if (ctrl.step) begin
      cnt  <= cnt + inc;
      prev <= code_bit;
    end
  end

  assign pair_count = cnt[CNT_W-1:1];

endmodule

### hdl/ir_biphase_pronto_encoder.sv
// Top level: Pronto raw word sequencer for 12-bit biphase IR codes.
// The first word is driven after the bit-serial count pass, at the start of the preamble.
// A new transaction is taken only in idle, once the previous one has ended;
// the merge loop handles one half bit per cycle.
// Words go out one per strobe cycle; the receiver cannot stall.
// Reset: synchronous, returns to idle and sets the carrier word to 0x006d.
module ir_biphase_pronto_encoder
  import irbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [3:0]  device_code,
  input  logic [7:0]  command_code,
  output logic        busy,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  output logic        strobe,
  output logic [15:0] pronto_word,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_PRE,
    S_HDR,
    S_BITS,
    S_TAIL,
    S_CLOSE,
    S_FLUSH
  } state_t;

  state_t             state;
  logic [CODE_W-1:0]  code_sr;
  logic [STEP_W-1:0]  step;
  logic               pend_on;
  logic [DUR_W-1:0]   pend_mag;
  logic [15:0]        carrier_word;
  logic [CNT_W-2:0]   pair_count;
  cnt_ctrl_t          cnt_ctrl;
  logic               accept;
  logic               half_on;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign half_on = step[0] ? code_sr[CODE_W-1] : !code_sr[CODE_W-1];

  always_comb begin
    cnt_ctrl.clear = accept;
    cnt_ctrl.step  = (state == S_COUNT);
    cnt_ctrl.first = (step == '0);
    cnt_ctrl.last  = (step == CODE_LAST);
  end

  irbp_pair_cnt u_pair_cnt (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (cnt_ctrl),
    .code_bit   (code_sr[CODE_W-1]),
    .pair_count (pair_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_word <= CARRIER_RST;
    end else if (wr_en) begin
      carrier_word <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      strobe    <= 1'b0;
      last_word <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      last_word <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            code_sr <= {device_code, command_code};
            step    <= '0;
            state   <= S_COUNT;
          end
        end
        S_COUNT: begin
          code_sr <= {code_sr[CODE_W-2:0], code_sr[CODE_W-1]};
          if (step == CODE_LAST) begin
            step  <= '0;
            state <= S_PRE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_PRE: begin
          strobe <= 1'b1;
          case (step)
            PRE_ZERO0:   pronto_word <= 16'h0000;
            PRE_CARRIER: pronto_word <= carrier_word;
            PRE_ZERO1:   pronto_word <= 16'h0000;
            PRE_COUNT:   pronto_word <= {{(16-CNT_W+1){1'b0}}, pair_count};
            default:     pronto_word <= 16'h0000;
          endcase
          if (step == PRE_LAST) begin
            step  <= '0;
            state <= S_HDR;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_HDR: begin
          strobe      <= 1'b1;
          pronto_word <= {{(16-DUR_W){1'b0}}, hdr_dur(step)};
          if (step == HDR_LAST) begin
            step     <= '0;
            pend_on  <= 1'b0;
            pend_mag <= HDR_TAIL;
            state    <= S_BITS;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_BITS: begin
          if (half_on == pend_on) begin
            pend_mag <= pend_mag + HALF_BIT;
          end else begin
            strobe      <= 1'b1;
            pronto_word <= {{(16-DUR_W){1'b0}}, pend_mag};
            pend_on     <= half_on;
            pend_mag    <= HALF_BIT;
          end
          if (step[0]) begin
            code_sr <= {code_sr[CODE_W-2:0], 1'b0};
          end
          if (step == HALF_LAST) begin
            step  <= '0;
            state <= S_TAIL;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_TAIL: begin
          strobe      <= 1'b1;
          pronto_word <= {{(16-DUR_W){1'b0}}, pend_mag};
          last_word   <= !pend_on;
          state       <= pend_on ? S_CLOSE : S_FLUSH;
        end
        S_CLOSE: begin
          strobe      <= 1'b1;
          pronto_word <= {{(16-DUR_W){1'b0}}, CLOSE_DUR};
          last_word   <= 1'b1;
          state       <= S_FLUSH;
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/irbp_checker.sv
// Port-level checker for the Pronto encoder and its bind to the top level.
`include "assert_macros.svh"

module irbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic        last_word
);

  `ASSERT_IMPL(a_strobe_busy, clk, rst, strobe, busy, "word strobe outside a transaction")
  `ASSERT_IMPL(a_last_strobe, clk, rst, last_word, strobe, "last_word without strobe")
  `ASSERT_NEXT(a_last_ends, clk, rst, strobe && last_word, !strobe && !busy, "activity after last word")
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !strobe, "transaction not taken")

endmodule

bind ir_biphase_pronto_encoder irbp_checker u_irbp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .last_word (last_word)
);
